FILE: sv/sts_pkg.sv
`default_nettype none

package sts_pkg;

   localparam int DEF_TABLE_DEPTH  = 1024;
   localparam int DEF_RECORD_WIDTH = 32;

   localparam int FUNC_W     = 1;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_SIGNED = 1'b1;

endpackage

`default_nettype wire

FILE: sv/sts_table.sv
`default_nettype none

module sts_table
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int RECORD_WIDTH = DEF_RECORD_WIDTH,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic [RECORD_WIDTH-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output      logic [RECORD_WIDTH-1:0] rd_data
);

   logic [RECORD_WIDTH-1:0] table_ff [TABLE_DEPTH];
   logic [RECORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/sts_ctrl.sv
`default_nettype none

module sts_ctrl
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int RECORD_WIDTH = DEF_RECORD_WIDTH,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire logic [FUNC_W-1:0]       req_func,
   input  wire logic [INDEX_W-1:0]      req_index,
   input  wire logic [VALUE_W-1:0]      req_value,
   input  wire logic [COUNT_W-1:0]      entry_count,
   input  wire logic                    compare_signed,
   output      logic                    wr_en,
   output      logic [AW-1:0]           wr_addr,
   output      logic [RECORD_WIDTH-1:0] wr_data,
   output      logic                    rd_en,
   output      logic [AW-1:0]           rd_addr,
   input  wire logic [RECORD_WIDTH-1:0] rd_data,
   output      logic                    rsp_valid,
   output      logic                    rsp_found,
   output      logic [INDEX_W-1:0]      rsp_position,
   output      logic [VALUE_W-1:0]      rsp_record
);

   localparam int NW   = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = (NW > COUNT_W) ? NW : COUNT_W;
   localparam int IW_X = (NW > INDEX_W) ? NW : INDEX_W;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   localparam logic [RECORD_WIDTH-1:0] SIGN_BIT = RECORD_WIDTH'(1) << (RECORD_WIDTH - 1);

   logic                    state_ff, state_in;
   logic [RECORD_WIDTH-1:0] key_ff, key_in;
   logic [NW-1:0]           lo_ff, lo_in;
   logic [NW-1:0]           hix_ff, hix_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]      rsp_position_ff, rsp_position_in;
   logic [VALUE_W-1:0]      rsp_record_ff, rsp_record_in;

   logic                    accept;
   logic [CW-1:0]           cnt_ext;
   logic [NW-1:0]           n_sat;
   logic [NW:0]             first_sum;
   logic                    idx_ok;
   logic [RECORD_WIDTH-1:0] rec_key;
   logic                    less;
   logic                    equal;
   logic [NW-1:0]           lo_next;
   logic [NW-1:0]           hix_next;
   logic                    done;
   logic [NW:0]             mid_sum;

   assign busy    = (state_ff == ST_SEARCH);
   assign accept  = start && !busy;

   // records past the table depth are never searched
   assign cnt_ext = CW'(entry_count);
   assign n_sat   = (cnt_ext > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(cnt_ext);

   assign first_sum = (NW + 1)'(n_sat) - (NW + 1)'(1);
   assign idx_ok    = IW_X'(req_index) < IW_X'(TABLE_DEPTH);

   assign rec_key  = compare_signed ? (rd_data ^ SIGN_BIT) : rd_data;
   assign less     = key_ff < rec_key;
   assign equal    = key_ff == rec_key;
   assign lo_next  = less ? lo_ff : (NW'(pos_ff) + NW'(1));
   assign hix_next = less ? NW'(pos_ff) : hix_ff;
   assign done     = equal || !(lo_next < hix_next);
   assign mid_sum  = (NW + 1)'(lo_next) + (NW + 1)'(hix_next) - (NW + 1)'(1);

   assign wr_en   = accept && (req_func == FUNC_WRITE) && idx_ok;
   assign wr_addr = AW'(req_index);
   assign wr_data = RECORD_WIDTH'(req_value);

   always_comb begin
      state_in        = state_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hix_in          = hix_ff;
      pos_in          = pos_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = 1'b0;
      rsp_position_in = '0;
      rsp_record_in   = '0;
      rd_en           = 1'b0;
      rd_addr         = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_func == FUNC_SEARCH) && (n_sat != '0)) begin
                  key_in   = compare_signed ? (RECORD_WIDTH'(req_value) ^ SIGN_BIT)
                                            : RECORD_WIDTH'(req_value);
                  lo_in    = '0;
                  hix_in   = n_sat;
                  pos_in   = first_sum[AW:1];
                  rd_en    = 1'b1;
                  rd_addr  = first_sum[AW:1];
                  state_in = ST_SEARCH;
               end else begin
                  // write item or empty table
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (done) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = equal;
               rsp_position_in = INDEX_W'(pos_ff);
               rsp_record_in   = VALUE_W'(rd_data);
               state_in        = ST_IDLE;
            end else begin
               lo_in   = lo_next;
               hix_in  = hix_next;
               pos_in  = mid_sum[AW:1];
               rd_en   = 1'b1;
               rd_addr = mid_sum[AW:1];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hix_ff          <= hix_in;
      pos_ff          <= pos_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_record_ff   <= rsp_record_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_record   = rsp_record_ff;

endmodule

`default_nettype wire

FILE: sv/sorted_table_binary_search.sv
// Sorted table binary search. Write items (func 0) store one record and answer
// in the next cycle with found 0, position 0, record 0. A search item (func 1)
// probes the table once per cycle through the single read port of the record
// memory, holding busy while it probes, at most floor(log2(n)) + 1 probes for n
// searched records (11 for a full 1024-entry table); start may be raised again
// the cycle busy falls. Each item gives exactly one result, shown for a single
// cycle on rsp_valid. There is no backpressure: the receiver must take every
// result when it appears. Write entry_count and compare_signed only while no
// item is in flight.
`default_nettype none

module sorted_table_binary_search
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int RECORD_WIDTH = DEF_RECORD_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [INDEX_W-1:0]    req_index,
   input  wire logic [VALUE_W-1:0]    req_value,
   output      logic                  rsp_valid,
   output      logic                  rsp_found,
   output      logic [INDEX_W-1:0]    rsp_position,
   output      logic [VALUE_W-1:0]    rsp_record,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [COUNT_W-1:0]      entry_count_ff, entry_count_in;
   logic                    compare_signed_ff, compare_signed_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [RECORD_WIDTH-1:0] wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [RECORD_WIDTH-1:0] rd_data;

   always_comb begin
      entry_count_in    = entry_count_ff;
      compare_signed_in = compare_signed_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:    entry_count_in    = COUNT_W'(csr_wdata);
            CSR_COMPARE_SIGNED: compare_signed_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff    <= '0;
         compare_signed_ff <= 1'b0;
      end else begin
         entry_count_ff    <= entry_count_in;
         compare_signed_ff <= compare_signed_in;
      end
   end

   sts_table #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .RECORD_WIDTH (RECORD_WIDTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sts_ctrl #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .RECORD_WIDTH (RECORD_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_index      (req_index),
      .req_value      (req_value),
      .entry_count    (entry_count_ff),
      .compare_signed (compare_signed_ff),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_record     (rsp_record)
   );

endmodule

`default_nettype wire

FILE: verif/sorted_table_binary_search_tb.sv
module sorted_table_binary_search_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sts_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;
   localparam int QUIET_LIMIT = 500;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] position;
      logic [VALUE_W-1:0] record;
   } answer_type;

   localparam answer_type NO_ANSWER   = '0;
   localparam answer_type HIT_AT_ZERO = '{found: 1'b1, position: '0, record: '0};

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [FUNC_W-1:0]     func;
      logic [INDEX_W-1:0]    index;
      logic [VALUE_W-1:0]    value;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      bit                    fixed;
      answer_type            answer;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [INDEX_W-1:0]    req_index = '0;
   logic [VALUE_W-1:0]    req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_found;
   logic [INDEX_W-1:0]    rsp_position;
   logic [VALUE_W-1:0]    rsp_record;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // typed-in answer that travels with the item being offered
   bit                    row_fixed = 1'b0;
   answer_type            row_answer = '0;

   logic [VALUE_W-1:0]    shadow_records [DEPTH];
   logic [COUNT_W-1:0]    shadow_count = '0;
   logic                  shadow_signed = 1'b0;

   answer_type            pending_answers [$];
   stim_row_type          directed_rows [$];
   int                    mismatch_count = 0;
   int                    quiet_cycles = 0;
   int                    burst_left = 0;

   sorted_table_binary_search dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_index    (req_index),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_record   (rsp_record),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic answer_type search_or_store(input logic [FUNC_W-1:0] func,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [VALUE_W-1:0] val);
      answer_type         ans;
      int                 lo, hi, mid, n, order;
      logic [VALUE_W-1:0] flip, key, probe_key;
      ans = '0;
      if (func == FUNC_WRITE) begin
         shadow_records[idx] = val;
         return ans;
      end
      n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
      if (n == 0) return ans;
      flip = shadow_signed ? SIGN_FLIP : '0;
      key = val ^ flip;
      lo = 0;
      hi = n - 1;
      mid = 0;
      order = 0;
      do begin
         mid = (lo + hi) / 2;
         ans.record = shadow_records[mid];
         probe_key = ans.record ^ flip;
         if (key < probe_key) begin
            order = -1;
            hi = mid - 1;
         end else begin
            order = (key > probe_key) ? 1 : 0;
            lo = mid + 1;
         end
      end while (order != 0 && lo <= hi);
      ans.found = (order == 0);
      ans.position = mid[INDEX_W-1:0];
      return ans;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      answer_type predicted;
      answer_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
               flag_mismatch("result with no item waiting");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_found !== want.found)
                  flag_mismatch($sformatf("found %b, wanted %b", rsp_found, want.found));
               if (rsp_position !== want.position)
                  flag_mismatch($sformatf("position %0d, wanted %0d",
                                          rsp_position, want.position));
               if (rsp_record !== want.record)
                  flag_mismatch($sformatf("record %h, wanted %h", rsp_record, want.record));
            end
         end
         if (start && busy === 1'b0) begin
            predicted = search_or_store(req_func, req_index, req_value);
            pending_answers.push_back(row_fixed ? row_answer : predicted);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sorted_table_binary_search: mismatch");
         $finish;
      end
   end

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      end
      burst_left--;
   endtask

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val, input bit fixed,
                            input answer_type answer);
      pace_sender();
      start <= 1'b1;
      req_func <= func;
      req_index <= idx;
      req_value <= val;
      row_fixed <= fixed;
      row_answer <= answer;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending_answers.size() != 0 || busy !== 1'b0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] which,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      if (which == CSR_ENTRY_COUNT) shadow_count = data;
      else shadow_signed = data[0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // upper bits of the data word carry noise
   task automatic set_compare(input bit mode);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      data[0] = mode;
      write_reg(CSR_COMPARE_SIGNED, data);
   endtask

   function automatic stim_row_type item_row(input logic [FUNC_W-1:0] func,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic [VALUE_W-1:0] val, input bit fixed,
                                             input answer_type answer);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.func = func;
      row.index = idx;
      row.value = val;
      row.reg_index = '0;
      row.reg_data = '0;
      row.fixed = fixed;
      row.answer = answer;
      return row;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_IDX_W-1:0] which,
                                            input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = item_row(FUNC_WRITE, '0, '0, 1'b0, NO_ANSWER);
      row.kind = ROW_REG;
      row.reg_index = which;
      row.reg_data = data;
      return row;
   endfunction

   // writes records 0..n-1 in shuffled order, ascending in the chosen compare, plus optional noise records past n
   task automatic load_sorted_table(input int n, input bit signed_order, input bit add_noise);
      int                 slot [DEPTH];
      logic [VALUE_W-1:0] sorted_vals [DEPTH];
      logic [63:0]        key;
      logic [VALUE_W-1:0] flip;
      int                 i, j, tmp, step_bits;
      flip = signed_order ? SIGN_FLIP : '0;
      step_bits = $urandom_range(0, (n > 64) ? 21 : 26);
      key = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom >> $urandom_range(1, 31));
      for (i = 0; i < n; i++) begin
         if (key > 64'hFFFF_FFFF) key = 64'hFFFF_FFFF;
         sorted_vals[i] = key[31:0] ^ flip;
         if ($urandom_range(0, 5) != 0) key = key + 64'($urandom_range(1, 1 << step_bits));
         slot[i] = i;
      end
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slot[i];
         slot[i] = slot[j];
         slot[j] = tmp;
      end
      for (i = 0; i < n; i++) begin
         send_item(FUNC_WRITE, INDEX_W'(slot[i]), sorted_vals[slot[i]], 1'b0, NO_ANSWER);
         if (add_noise && n < DEPTH && $urandom_range(0, 7) == 0)
            send_item(FUNC_WRITE, INDEX_W'($urandom_range(n, DEPTH - 1)), $urandom,
                      1'b0, NO_ANSWER);
      end
   endtask

   // searches only ever probe the written prefix
   task automatic search_burst(input int count, input bit break_order);
      int                 i, span, pick;
      logic [VALUE_W-1:0] key;
      span = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 59) == 0) drain_results();
         if (break_order && span != 0 && $urandom_range(0, 9) == 0)
            send_item(FUNC_WRITE, INDEX_W'($urandom_range(0, span - 1)), $urandom,
                      1'b0, NO_ANSWER);
         pick = $urandom_range(0, 19);
         if (span == 0 || pick >= 17) begin
            key = $urandom;
         end else if (pick < 10) begin
            key = shadow_records[$urandom_range(0, span - 1)];
         end else if (pick < 14) begin
            key = shadow_records[$urandom_range(0, span - 1)];
            key = $urandom_range(0, 1) ? key + 1 : key - 1;
         end else begin
            case ($urandom_range(0, 3))
               0: key = '0;
               1: key = '1;
               2: key = 32'h7FFF_FFFF;
               default: key = SIGN_FLIP;
            endcase
         end
         send_item(FUNC_SEARCH, INDEX_W'($urandom), key, 1'b0, NO_ANSWER);
      end
   endtask

   initial begin
      stim_row_type row;
      int           round, n;
      bit           mode;

      // empty table, then extremes of records and index
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, '0, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_SEARCH, '1, '1, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd0, 32'h0000_0000, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd1, 32'h0000_0005, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd2, 32'h0000_0010, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd3, 32'h7FFF_FFFF, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd4, 32'h8000_0000, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd5, 32'h8000_0001, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd6, 32'hFFFF_FFFE, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd7, 32'hFFFF_FFFF, 1'b1, NO_ANSWER));
      directed_rows.push_back(reg_row(CSR_ENTRY_COUNT, 11'd8));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h0000_0010, 1'b0, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h0000_0000, 1'b0, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_SEARCH, '1, 32'hFFFF_FFFF, 1'b0, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h0000_0011, 1'b0, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h8000_0000, 1'b0, NO_ANSWER));
      // signed compare over a table sorted as unsigned
      directed_rows.push_back(reg_row(CSR_COMPARE_SIGNED, 11'd1));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'hFFFF_FFFF, 1'b0, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h7FFF_FFFF, 1'b0, NO_ANSWER));
      directed_rows.push_back(reg_row(CSR_ENTRY_COUNT, 11'd1));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h0000_0000, 1'b1, HIT_AT_ZERO));
      directed_rows.push_back(item_row(FUNC_SEARCH, '0, 32'h0000_0005, 1'b1, NO_ANSWER));
      directed_rows.push_back(item_row(FUNC_WRITE, 10'd1023, 32'hFFFF_FFFF, 1'b1, NO_ANSWER));

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_REG) write_reg(row.reg_index, row.reg_data);
         else send_item(row.func, row.index, row.value, row.fixed, row.answer);
      end

      for (round = 0; round < 5; round++) begin
         mode = $urandom_range(0, 1);
         if (round == 2) begin
            load_sorted_table(DEPTH, mode, 1'b0);
            set_compare(mode);
            write_reg(CSR_ENTRY_COUNT, 11'd1024);
            search_burst(25, 1'b0);
            write_reg(CSR_ENTRY_COUNT, '1);
            search_burst(25, 1'b0);
            write_reg(CSR_ENTRY_COUNT, CSR_DATA_W'($urandom_range(1025, 2046)));
            search_burst(25, 1'b0);
            write_reg(CSR_ENTRY_COUNT, CSR_DATA_W'($urandom_range(1, 1023)));
            search_burst(25, 1'b0);
         end else begin
            n = $urandom_range(1, 40);
            load_sorted_table(n, mode, 1'b1);
            set_compare(mode);
            write_reg(CSR_ENTRY_COUNT,
                      CSR_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n));
            search_burst(30, round % 2 == 1);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("sorted_table_binary_search: match");
      end else begin
         $display("sorted_table_binary_search: mismatch");
      end
      $finish;
   end

endmodule

FILE: sorted_table_binary_search.f
sv/sts_pkg.sv
sv/sts_table.sv
sv/sts_ctrl.sv
sv/sorted_table_binary_search.sv
verif/sorted_table_binary_search_tb.sv
